/* rtl/rhh_pkg.sv */
`default_nettype none
package rhh_pkg;

  // Datapath widths of the rotation chain. They are sized for the largest
  // component width the block supports, so they do not vary.
  localparam int XW            = 45;
  localparam int ZW            = 35;
  localparam int ANGLE_FRAC    = 24;
  localparam int CORDIC_STEPS  = 26;
  localparam int NORM_BIT      = 40;
  localparam int SQRT3_Q16     = 113512;
  localparam int LATENCY       = CORDIC_STEPS + 3;

  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'd180 << ANGLE_FRAC);
  localparam logic signed [ZW-1:0] FULL_TURN = ZW'(64'd360 << ANGLE_FRAC);

  typedef struct packed {
    logic valid;
    logic hsl;
    logic flag;
    logic sat_zero;
  } ctl_t;

  // Arctangent of 2^-i in units of 2^-24 degree.
  function automatic logic signed [ZW-1:0] atan_deg(input int idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:  a = ZW'(754974720);
      1:  a = ZW'(445687602);
      2:  a = ZW'(235489088);
      3:  a = ZW'(119537938);
      4:  a = ZW'(60000934);
      5:  a = ZW'(30029717);
      6:  a = ZW'(15018523);
      7:  a = ZW'(7509720);
      8:  a = ZW'(3754917);
      9:  a = ZW'(1877466);
      10: a = ZW'(938734);
      11: a = ZW'(469367);
      12: a = ZW'(234684);
      13: a = ZW'(117342);
      14: a = ZW'(58671);
      15: a = ZW'(29335);
      16: a = ZW'(14668);
      17: a = ZW'(7334);
      18: a = ZW'(3667);
      19: a = ZW'(1833);
      20: a = ZW'(917);
      21: a = ZW'(458);
      22: a = ZW'(229);
      23: a = ZW'(115);
      24: a = ZW'(57);
      25: a = ZW'(29);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

/* rtl/rhh_prep.sv */
`default_nettype none
module rhh_prep #(
  parameter int CB = 16,
  parameter int FB = 6
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     operation_i,
  input  wire logic [CB-1:0]            red_i,
  input  wire logic [CB-1:0]            green_i,
  input  wire logic [CB-1:0]            blue_i,
  input  wire logic [FB+8:0]            hue_i,
  input  wire logic [CB-1:0]            light_i,
  input  wire logic [CB-1:0]            sat_i,
  output rhh_pkg::ctl_t                 ctl_o,
  output logic signed [rhh_pkg::XW-1:0] x_o,
  output logic signed [rhh_pkg::XW-1:0] y_o,
  output logic [2*CB+1:0]               num_o,
  output logic [2*CB+1:0]               den_o,
  output logic [FB+8:0]                 hue_o,
  output logic [CB-1:0]                 inten_o
);
  import rhh_pkg::*;

  localparam int HW = FB + 9;
  localparam int DW = 2 * CB + 2;
  localparam int K  = ((CB + 4) / 2) * 2;
  localparam longint unsigned RECIP3 = ((64'd1 << K) + 64'd2) / 64'd3;
  localparam logic [HW-1:0] HUE_TOP = HW'(360 << FB);
  localparam logic [CB-1:0] CMAX = '1;

  ctl_t                   ctl_d, ctl_q;
  logic signed [XW-1:0]   x_d, x_q, y_d, y_q;
  logic [DW-1:0]          num_d, num_q, den_d, den_q;
  logic [HW-1:0]          hue_d, hue_q;
  logic [CB-1:0]          inten_d, inten_q;

  logic [CB+1:0]          sum, sum1, min3;
  logic signed [CB+2:0]   xs;
  logic signed [CB+1:0]   gb;
  logic signed [CB+19:0]  yprod;
  logic [CB+1+K:0]        iprod;
  logic [CB:0]            two_l, wone, dev, tval;
  logic [2*CB:0]          pval;
  logic [CB+1:0]          ihsl, irgb;
  logic                   black, gray;

  always_comb begin
    sum   = (CB+2)'(red_i) + (CB+2)'(green_i) + (CB+2)'(blue_i);
    sum1  = sum + (CB+2)'(1);
    min3  = (CB+2)'((red_i < green_i) ? red_i : green_i);
    if ((CB+2)'(blue_i) < min3) begin
      min3 = (CB+2)'(blue_i);
    end
    black = (sum == '0);
    gray  = (red_i == green_i) && (green_i == blue_i);
    // Division by three through a reciprocal that is exact over this range.
    iprod = (CB+2+K)'(sum1) * (CB+2+K)'(RECIP3);
    irgb  = (CB+2)'(iprod >> K);
    xs    = $signed((CB+3)'({red_i, 1'b0})) - $signed((CB+3)'(green_i))
          - $signed((CB+3)'(blue_i));
    gb    = $signed((CB+2)'(green_i)) - $signed((CB+2)'(blue_i));
    yprod = (CB+20)'(gb) * (CB+20)'($signed(19'(SQRT3_Q16)));

    two_l = {light_i, 1'b0};
    wone  = {1'b1, {CB{1'b0}}};
    dev   = (two_l >= wone) ? (two_l - wone) : (wone - two_l);
    tval  = wone - dev;
    pval  = (2*CB+1)'(sat_i) * (2*CB+1)'(tval);
    ihsl  = (CB+2)'(light_i)
          + (CB+2)'(((2*CB+2)'(pval) + (2*CB+2)'(wone)) >> (CB + 1));

    ctl_d.valid    = start_i;
    ctl_d.hsl      = operation_i;
    ctl_d.flag     = !operation_i && (black || gray);
    ctl_d.sat_zero = operation_i ? (light_i == '0) : black;
    x_d = XW'(xs) <<< 16;
    y_d = XW'(yprod);
    hue_d = (hue_i >= HUE_TOP) ? (hue_i - HUE_TOP) : hue_i;
    if (operation_i) begin
      num_d   = {pval, 1'b0};
      den_d   = DW'({light_i, {(CB+1){1'b0}}}) + DW'(pval);
      inten_d = (ihsl > (CB+2)'(CMAX)) ? CMAX : CB'(ihsl);
    end else begin
      num_d   = DW'(sum - (CB+2)'(3 * min3));
      den_d   = DW'(sum);
      inten_d = (irgb > (CB+2)'(CMAX)) ? CMAX : CB'(irgb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    num_q   <= num_d;
    den_q   <= den_d;
    hue_q   <= hue_d;
    inten_q <= inten_d;
  end

  assign ctl_o   = ctl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign hue_o   = hue_q;
  assign inten_o = inten_q;

endmodule
`default_nettype wire

/* rtl/rhh_norm.sv */
`default_nettype none
module rhh_norm #(
  parameter int CB = 16,
  parameter int FB = 6
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  rhh_pkg::ctl_t                 ctl_i,
  input  wire logic signed [rhh_pkg::XW-1:0] x_i,
  input  wire logic signed [rhh_pkg::XW-1:0] y_i,
  input  wire logic [2*CB+1:0]          num_i,
  input  wire logic [2*CB+1:0]          den_i,
  input  wire logic [FB+8:0]            hue_i,
  input  wire logic [CB-1:0]            inten_i,
  output rhh_pkg::ctl_t                 ctl_o,
  output logic signed [rhh_pkg::XW-1:0] x_o,
  output logic signed [rhh_pkg::XW-1:0] y_o,
  output logic signed [rhh_pkg::ZW-1:0] z_o,
  output logic [CB+1:0]                 q_o,
  output logic [2*CB+1:0]               rem_o,
  output logic [2*CB+1:0]               den_o,
  output logic [FB+8:0]                 hue_o,
  output logic [CB-1:0]                 inten_o
);
  import rhh_pkg::*;

  localparam int HW = FB + 9;
  localparam int DW = 2 * CB + 2;
  localparam int QW = CB + 2;

  ctl_t                 ctl_q;
  logic signed [XW-1:0] x_d, x_q, y_d, y_q, xr, yr;
  logic signed [ZW-1:0] z_d, z_q;
  logic [QW-1:0]        q_d, q_q;
  logic [DW-1:0]        rem_d, rem_q, den_q;
  logic [HW-1:0]        hue_q;
  logic [CB-1:0]        inten_q;
  logic [XW-1:0]        ax, ay, mag;
  logic [5:0]           sh;

  always_comb begin
    // Fold the vector into the right half plane.
    if (x_i < 0) begin
      xr  = -x_i;
      yr  = -y_i;
      z_d = HALF_TURN;
    end else begin
      xr  = x_i;
      yr  = y_i;
      z_d = '0;
    end
    ax  = xr;
    ay  = (yr < 0) ? XW'(-yr) : XW'(yr);
    mag = (ax > ay) ? ax : ay;
    // Leading-zero search in halving steps, then one last doubling so that
    // the larger magnitude lands on the normalizing bit.
    sh = '0;
    for (int j = 0; j < 6; j++) begin
      if (mag < (XW'(1) << (NORM_BIT - (32 >> j)))) begin
        mag = mag << (32 >> j);
        sh  = sh + 6'(32 >> j);
      end
    end
    if ((mag < (XW'(1) << NORM_BIT)) && (mag != '0)) begin
      sh = sh + 6'd1;
    end
    x_d = xr <<< sh;
    y_d = yr <<< sh;

    if (num_i >= den_i) begin
      q_d   = QW'(1);
      rem_d = num_i - den_i;
    end else begin
      q_d   = '0;
      rem_d = num_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    q_q     <= q_d;
    rem_q   <= rem_d;
    den_q   <= den_i;
    hue_q   <= hue_i;
    inten_q <= inten_i;
  end

  assign ctl_o   = ctl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign q_o     = q_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign hue_o   = hue_q;
  assign inten_o = inten_q;

endmodule
`default_nettype wire

/* rtl/rhh_cell.sv */
`default_nettype none
module rhh_cell #(
  parameter int CB  = 16,
  parameter int FB  = 6,
  parameter int IDX = 0
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  rhh_pkg::ctl_t                 ctl_i,
  input  wire logic signed [rhh_pkg::XW-1:0] x_i,
  input  wire logic signed [rhh_pkg::XW-1:0] y_i,
  input  wire logic signed [rhh_pkg::ZW-1:0] z_i,
  input  wire logic [CB+1:0]            q_i,
  input  wire logic [2*CB+1:0]          rem_i,
  input  wire logic [2*CB+1:0]          den_i,
  input  wire logic [FB+8:0]            hue_i,
  input  wire logic [CB-1:0]            inten_i,
  output rhh_pkg::ctl_t                 ctl_o,
  output logic signed [rhh_pkg::XW-1:0] x_o,
  output logic signed [rhh_pkg::XW-1:0] y_o,
  output logic signed [rhh_pkg::ZW-1:0] z_o,
  output logic [CB+1:0]                 q_o,
  output logic [2*CB+1:0]               rem_o,
  output logic [2*CB+1:0]               den_o,
  output logic [FB+8:0]                 hue_o,
  output logic [CB-1:0]                 inten_o
);
  import rhh_pkg::*;

  localparam int  HW     = FB + 9;
  localparam int  DW     = 2 * CB + 2;
  localparam int  QW     = CB + 2;
  // The long division needs one cell per quotient bit below the integer bit.
  localparam bit  DO_DIV = (IDX <= CB);

  ctl_t                 ctl_q;
  logic signed [XW-1:0] x_d, x_q, y_d, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  logic [QW-1:0]        q_d, q_q;
  logic [DW-1:0]        rem_d, rem_q, den_q;
  logic [HW-1:0]        hue_q;
  logic [CB-1:0]        inten_q;
  logic [DW:0]          rem2;

  always_comb begin
    if (!y_i[XW-1]) begin
      x_d = x_i + (y_i >>> IDX);
      y_d = y_i - (x_i >>> IDX);
      z_d = z_i + atan_deg(IDX);
    end else begin
      x_d = x_i - (y_i >>> IDX);
      y_d = y_i + (x_i >>> IDX);
      z_d = z_i - atan_deg(IDX);
    end

    rem2 = {rem_i, 1'b0};
    q_d   = q_i;
    rem_d = rem_i;
    if (DO_DIV) begin
      if (rem2 >= {1'b0, den_i}) begin
        rem_d = DW'(rem2 - {1'b0, den_i});
        q_d   = {q_i[QW-2:0], 1'b1};
      end else begin
        rem_d = DW'(rem2);
        q_d   = {q_i[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    q_q     <= q_d;
    rem_q   <= rem_d;
    den_q   <= den_i;
    hue_q   <= hue_i;
    inten_q <= inten_i;
  end

  assign ctl_o   = ctl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign q_o     = q_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign hue_o   = hue_q;
  assign inten_o = inten_q;

endmodule
`default_nettype wire

/* rtl/rhh_post.sv */
`default_nettype none
module rhh_post #(
  parameter int CB = 16,
  parameter int FB = 6
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  rhh_pkg::ctl_t                 ctl_i,
  input  wire logic signed [rhh_pkg::ZW-1:0] z_i,
  input  wire logic [CB+1:0]            q_i,
  input  wire logic [FB+8:0]            hue_i,
  input  wire logic [CB-1:0]            inten_i,
  output logic                          done_o,
  output logic [FB+8:0]                 hue_o,
  output logic [CB-1:0]                 sat_o,
  output logic [CB-1:0]                 inten_o,
  output logic                          flag_o
);
  import rhh_pkg::*;

  localparam int HW = FB + 9;
  localparam int QW = CB + 2;
  localparam int SH = ANGLE_FRAC - FB;
  localparam logic signed [ZW-1:0] RND     = ZW'(64'd1 << (SH - 1));
  localparam logic signed [ZW-1:0] HUE_TOP = ZW'(360 << FB);
  localparam logic [CB-1:0]        CMAX    = '1;

  logic                 done_q;
  logic [HW-1:0]        hue_d, hue_q;
  logic [CB-1:0]        sat_d, sat_q, inten_q;
  logic                 flag_q;
  logic signed [ZW-1:0] zz, hh;
  logic [QW:0]          qr;

  always_comb begin
    zz = z_i;
    if (zz < 0) begin
      zz = zz + FULL_TURN;
    end
    if (zz < 0) begin
      zz = '0;
    end
    hh = (zz + RND) >>> SH;
    if (hh >= HUE_TOP) begin
      hh = hh - HUE_TOP;
    end
    if (ctl_i.hsl) begin
      hue_d = hue_i;
    end else if (ctl_i.flag) begin
      hue_d = '0;
    end else begin
      hue_d = HW'(hh);
    end
    qr = ((QW+1)'(q_i) + (QW+1)'(1)) >> 1;
    if (ctl_i.sat_zero) begin
      sat_d = '0;
    end else if (qr > (QW+1)'(CMAX)) begin
      sat_d = CMAX;
    end else begin
      sat_d = CB'(qr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q   <= hue_d;
    sat_q   <= sat_d;
    inten_q <= inten_i;
    flag_q  <= ctl_i.flag;
  end

  assign done_o  = done_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;
  assign inten_o = inten_q;
  assign flag_o  = flag_q;

endmodule
`default_nettype wire

/* rtl/rgb_hsl_to_hsi_converter_top.sv */
// Channel  | Ports                                        | Beat taken when
// ---------+----------------------------------------------+------------------
// command  | start_i, busy_o, operation_i, color fields   | start_i && !busy_o
// result   | done_o, hue/saturation/intensity, flag       | done_o (one cycle)
//
// One item may be started in every cycle; busy_o never rises.
// Each result passes through one input stage, one normalizing stage,
// 26 rotation cells and one output stage, all registered.
// Rotation cells 0 to CB also do the saturation long division, a bit each.
// Reset clears only the ctl fields of the chain; results in flight are lost.
// The receiver cannot stall, so nothing ever holds the chain.
`default_nettype none
module rgb_hsl_to_hsi_converter_top #(
  parameter int COMPONENT_BITS    = 16,
  parameter int HUE_FRACTION_BITS = 6
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic                              operation_i,
  input  wire logic [COMPONENT_BITS-1:0]         red_level_i,
  input  wire logic [COMPONENT_BITS-1:0]         green_level_i,
  input  wire logic [COMPONENT_BITS-1:0]         blue_level_i,
  input  wire logic [HUE_FRACTION_BITS+8:0]      hsl_hue_in_i,
  input  wire logic [COMPONENT_BITS-1:0]         hsl_lightness_i,
  input  wire logic [COMPONENT_BITS-1:0]         hsl_saturation_i,
  output logic                                   done_o,
  output logic [HUE_FRACTION_BITS+8:0]           hue_out_o,
  output logic [COMPONENT_BITS-1:0]              saturation_out_o,
  output logic [COMPONENT_BITS-1:0]              intensity_out_o,
  output logic                                   degenerate_flag_o
);
  import rhh_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int FB = HUE_FRACTION_BITS;
  localparam int HW = FB + 9;
  localparam int DW = 2 * CB + 2;
  localparam int QW = CB + 2;
  localparam int N  = CORDIC_STEPS;

  ctl_t                 prep_ctl;
  logic signed [XW-1:0] prep_x, prep_y;
  logic [DW-1:0]        prep_num, prep_den;
  logic [HW-1:0]        prep_hue;
  logic [CB-1:0]        prep_inten;

  ctl_t                 c_ctl   [N+1];
  logic signed [XW-1:0] c_x     [N+1];
  logic signed [XW-1:0] c_y     [N+1];
  logic signed [ZW-1:0] c_z     [N+1];
  logic [QW-1:0]        c_q     [N+1];
  logic [DW-1:0]        c_rem   [N+1];
  logic [DW-1:0]        c_den   [N+1];
  logic [HW-1:0]        c_hue   [N+1];
  logic [CB-1:0]        c_inten [N+1];

  assign busy_o = 1'b0;

  rhh_prep #(.CB(CB), .FB(FB)) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i && !busy_o),
    .operation_i (operation_i),
    .red_i       (red_level_i),
    .green_i     (green_level_i),
    .blue_i      (blue_level_i),
    .hue_i       (hsl_hue_in_i),
    .light_i     (hsl_lightness_i),
    .sat_i       (hsl_saturation_i),
    .ctl_o       (prep_ctl),
    .x_o         (prep_x),
    .y_o         (prep_y),
    .num_o       (prep_num),
    .den_o       (prep_den),
    .hue_o       (prep_hue),
    .inten_o     (prep_inten)
  );

  rhh_norm #(.CB(CB), .FB(FB)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (prep_ctl),
    .x_i     (prep_x),
    .y_i     (prep_y),
    .num_i   (prep_num),
    .den_i   (prep_den),
    .hue_i   (prep_hue),
    .inten_i (prep_inten),
    .ctl_o   (c_ctl[0]),
    .x_o     (c_x[0]),
    .y_o     (c_y[0]),
    .z_o     (c_z[0]),
    .q_o     (c_q[0]),
    .rem_o   (c_rem[0]),
    .den_o   (c_den[0]),
    .hue_o   (c_hue[0]),
    .inten_o (c_inten[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    rhh_cell #(.CB(CB), .FB(FB), .IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (c_ctl[i]),
      .x_i     (c_x[i]),
      .y_i     (c_y[i]),
      .z_i     (c_z[i]),
      .q_i     (c_q[i]),
      .rem_i   (c_rem[i]),
      .den_i   (c_den[i]),
      .hue_i   (c_hue[i]),
      .inten_i (c_inten[i]),
      .ctl_o   (c_ctl[i+1]),
      .x_o     (c_x[i+1]),
      .y_o     (c_y[i+1]),
      .z_o     (c_z[i+1]),
      .q_o     (c_q[i+1]),
      .rem_o   (c_rem[i+1]),
      .den_o   (c_den[i+1]),
      .hue_o   (c_hue[i+1]),
      .inten_o (c_inten[i+1])
    );
  end

  rhh_post #(.CB(CB), .FB(FB)) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (c_ctl[N]),
    .z_i     (c_z[N]),
    .q_i     (c_q[N]),
    .hue_i   (c_hue[N]),
    .inten_i (c_inten[N]),
    .done_o  (done_o),
    .hue_o   (hue_out_o),
    .sat_o   (saturation_out_o),
    .inten_o (intensity_out_o),
    .flag_o  (degenerate_flag_o)
  );

endmodule
`default_nettype wire

/* rtl/rhh_checker.sv */
`default_nettype none
module rhh_checker #(
  parameter int COMPONENT_BITS    = 16,
  parameter int HUE_FRACTION_BITS = 6
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start_i,
  input wire logic                              busy_o,
  input wire logic                              done_o,
  input wire logic [HUE_FRACTION_BITS+8:0]      hue_out_o,
  input wire logic [COMPONENT_BITS-1:0]         saturation_out_o,
  input wire logic                              degenerate_flag_o
);
  import rhh_pkg::*;

  localparam int HW = HUE_FRACTION_BITS + 9;
  localparam logic [HW-1:0] HUE_TOP = HW'(360 << HUE_FRACTION_BITS);

  // Every accepted beat comes out as a done_o result at the end of the pipeline.
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("accepted beat produced no result");

  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without a matching accepted beat");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised in a fully pipelined design");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hue_out_o < HUE_TOP))
    else $error("hue out of range");

  a_flag_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_flag_o) |-> ((hue_out_o == '0) && (saturation_out_o == '0)))
    else $error("degenerate result with nonzero hue or saturation");

endmodule

bind rgb_hsl_to_hsi_converter_top rhh_checker #(
  .COMPONENT_BITS    (COMPONENT_BITS),
  .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
) u_rhh_checker (.*);
`default_nettype wire

/* tb/sv/rgb_hsl_to_hsi_converter_top_tb.sv */
`default_nettype none
module rgb_hsl_to_hsi_converter_top_tb;
  import rhh_pkg::*;

  localparam int CB = 16;
  localparam int HB = 15;
  localparam int HUE_TOP = 360 * 64;
  localparam logic OP_RGB = 1'b0;
  localparam logic OP_HSL = 1'b1;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [HB-1:0] hue;
    logic [CB-1:0] sat;
    logic [CB-1:0] inten;
    logic          flag;
  } hsi_t;

  // Rounded fraction num/den in Q1.16, num < 2*den.
  function automatic longint frac_round(longint num, longint den);
    longint q;
    longint r;
    q = num / den;
    r = num % den;
    for (int k = 0; k <= CB; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return (q + 1) >>> 1;
  endfunction

  function automatic longint fshift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint atan_q24(int i);
    longint t[26] = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
                      117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
                      115, 57, 29};
    return t[i];
  endfunction

  function automatic longint angle_of(longint r, longint g, longint b);
    longint x, y, z, m, ay, nx, ny, h;
    x = (2 * r - g - b) * 65536;
    y = (g - b) * 113512;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(180) << 24;
    end
    ay = (y < 0) ? -y : y;
    m = (x > ay) ? x : ay;
    while (m > 0 && m < (longint'(1) << 40)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    for (int i = 0; i < 26; i++) begin
      if (y >= 0) begin
        nx = x + fshift(y, i);
        ny = y - fshift(x, i);
        z = z + atan_q24(i);
      end else begin
        nx = x - fshift(y, i);
        ny = y + fshift(x, i);
        z = z - atan_q24(i);
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = z + (longint'(360) << 24);
    if (z < 0) z = 0;
    h = (z + (longint'(1) << 17)) >>> 18;
    if (h >= HUE_TOP) h = h - HUE_TOP;
    return h;
  endfunction

  function automatic hsi_t convert(logic op, logic [CB-1:0] r, logic [CB-1:0] g,
                                   logic [CB-1:0] b, logic [HB-1:0] hh,
                                   logic [CB-1:0] l, logic [CB-1:0] s);
    hsi_t o;
    longint sum, mn, hue, sat, inten, w, dev, p;
    w = 65536;
    hue = 0;
    sat = 0;
    inten = 0;
    o.flag = 1'b0;
    if (op == OP_RGB) begin
      sum = r + g + b;
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      if (sum == 0) begin
        o.flag = 1'b1;
      end else begin
        inten = (sum + 1) / 3;
        sat = frac_round(sum - 3 * mn, sum);
        if (r == g && g == b) o.flag = 1'b1;
        else hue = angle_of(r, g, b);
      end
    end else begin
      dev = (2 * l >= w) ? 2 * l - w : w - 2 * l;
      p = longint'(s) * (w - dev);
      hue = hh;
      if (hue >= HUE_TOP) hue = hue - HUE_TOP;
      inten = l + (p + w) / (2 * w);
      if (l != 0) sat = frac_round(2 * p, 2 * l * w + p);
    end
    if (sat > 65535) sat = 65535;
    if (inten > 65535) inten = 65535;
    o.hue = hue[HB-1:0];
    o.sat = sat[CB-1:0];
    o.inten = inten[CB-1:0];
    return o;
  endfunction

  class hsi_scoreboard;
    hsi_t pending[$];
    int errors = 0;

    function void note_color(hsi_t e);
      pending.push_back(e);
    endfunction

    function void check_color(hsi_t a);
      hsi_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat hue=%0d", a.hue);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.hue !== e.hue) begin
        $error("hue_out expected %0d actual %0d", e.hue, a.hue);
        errors++;
      end
      if (a.sat !== e.sat) begin
        $error("saturation_out expected %0d actual %0d", e.sat, a.sat);
        errors++;
      end
      if (a.inten !== e.inten) begin
        $error("intensity_out expected %0d actual %0d", e.inten, a.inten);
        errors++;
      end
      if (a.flag !== e.flag) begin
        $error("degenerate_flag expected %0d actual %0d", e.flag, a.flag);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic operation_i = 1'b0;
  logic [CB-1:0] red_level_i = '0, green_level_i = '0, blue_level_i = '0;
  logic [HB-1:0] hsl_hue_in_i = '0;
  logic [CB-1:0] hsl_lightness_i = '0, hsl_saturation_i = '0;
  logic busy_o, done_o, degenerate_flag_o;
  logic [HB-1:0] hue_out_o;
  logic [CB-1:0] saturation_out_o, intensity_out_o;

  hsi_scoreboard board = new();
  longint cycles = 0;
  int idle_pct = 0;

  rgb_hsl_to_hsi_converter_top dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    hsi_t got;
    cycles <= cycles + 1;
    if (rst_ni && done_o) begin
      got.hue = hue_out_o;
      got.sat = saturation_out_o;
      got.inten = intensity_out_o;
      got.flag = degenerate_flag_o;
      board.check_color(got);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("rgb_hsl_to_hsi_converter_top_tb: done, errors");
      $finish;
    end
  end

  // Drives one beat; start stays high across back-to-back beats.
  task automatic send_color(logic op, logic [CB-1:0] r, logic [CB-1:0] g,
                            logic [CB-1:0] b, logic [HB-1:0] hh,
                            logic [CB-1:0] l, logic [CB-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    operation_i <= op;
    red_level_i <= r;
    green_level_i <= g;
    blue_level_i <= b;
    hsl_hue_in_i <= hh;
    hsl_lightness_i <= l;
    hsl_saturation_i <= s;
    do @(posedge clk_i); while (busy_o);
    board.note_color(convert(op, r, g, b, hh, l, s));
    @(negedge clk_i);
  endtask

  task automatic send_random();
    logic [CB-1:0] r, g, b, v;
    logic [HB-1:0] hh;
    r = CB'($urandom);
    g = CB'($urandom);
    b = CB'($urandom);
    v = CB'($urandom);
    hh = HB'($urandom);
    case ($urandom_range(9))
      0: g = r;
      1: b = g;
      2: begin g = r; b = r; end
      3: begin r = r >> $urandom_range(15); g = g >> $urandom_range(15); end
      4: b = r + CB'($urandom_range(3));
      default: ;
    endcase
    send_color($urandom_range(1) ? OP_HSL : OP_RGB, r, g, b, hh,
               ($urandom_range(7) == 0) ? CB'(v >> $urandom_range(15)) : v, CB'($urandom));
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Extremes, black, gray, pure primaries, HSL hue wrap and zero lightness.
    send_color(OP_RGB, 0, 0, 0, 0, 0, 0);
    send_color(OP_RGB, 16'hffff, 16'hffff, 16'hffff, 0, 0, 0);
    send_color(OP_RGB, 100, 100, 100, 0, 0, 0);
    send_color(OP_RGB, 16'hffff, 0, 0, 0, 0, 0);
    send_color(OP_RGB, 0, 16'hffff, 0, 0, 0, 0);
    send_color(OP_RGB, 0, 0, 16'hffff, 0, 0, 0);
    send_color(OP_RGB, 0, 16'hffff, 16'hffff, 0, 0, 0);
    send_color(OP_RGB, 16'hffff, 0, 16'hffff, 0, 0, 0);
    send_color(OP_RGB, 1, 0, 0, 0, 0, 0);
    send_color(OP_RGB, 0, 0, 1, 0, 0, 0);
    send_color(OP_RGB, 16'hffff, 16'hfffe, 16'hffff, 0, 0, 0);
    send_color(OP_RGB, 16'h5555, 16'haaaa, 16'h0001, 0, 0, 0);
    send_color(OP_HSL, 0, 0, 0, 0, 0, 0);
    send_color(OP_HSL, 0, 0, 0, 15'h7fff, 16'hffff, 16'hffff);
    send_color(OP_HSL, 0, 0, 0, 15'd23039, 16'h8000, 16'hffff);
    send_color(OP_HSL, 0, 0, 0, 15'd23040, 16'h7fff, 16'h8000);
    send_color(OP_HSL, 16'hffff, 16'hffff, 16'hffff, 15'd100, 0, 16'hffff);
    send_color(OP_HSL, 0, 0, 0, 15'h5555, 1, 16'hffff);
    send_color(OP_HSL, 0, 0, 0, 15'h2aaa, 16'hffff, 0);
    drain();
    idle_pct = 19;
    repeat (450) send_random();
    drain();
    idle_pct = 80;
    repeat (450) send_random();
    idle_pct = 0;
    repeat (450) send_random();
    drain();
    repeat (LATENCY + 5) @(negedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("rgb_hsl_to_hsi_converter_top_tb: done, clean");
    else
      $display("rgb_hsl_to_hsi_converter_top_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

/* rgb_hsl_to_hsi_converter_top.f */
rtl/rhh_pkg.sv
rtl/rhh_prep.sv
rtl/rhh_norm.sv
rtl/rhh_cell.sv
rtl/rhh_post.sv
rtl/rgb_hsl_to_hsi_converter_top.sv
rtl/rhh_checker.sv
tb/sv/rgb_hsl_to_hsi_converter_top_tb.sv
